>>> rtl/core/sprite_pixel_collision_macros.svh
// Assertion macros used by the checker file.
`ifndef SPRITE_PIXEL_COLLISION_MACROS_SVH
`define SPRITE_PIXEL_COLLISION_MACROS_SVH

// Check cons in the cycle after ante.
`define SPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite_pixel_collision: check failed");

// Check cons in the same cycle as ante.
`define SPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite_pixel_collision: check failed");

`endif

>>> rtl/core/spc_pkg.sv
package spc_pkg;

	localparam int MAX_SIDE   = 16;
	localparam int MASK_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W     = $clog2(MASK_DEPTH);
	localparam int SIDE_W     = 5;
	localparam int POS_W      = 12;
	localparam int IDX_IN_W   = 8;
	localparam int OFF_W      = POS_W + 1;
	localparam int DX_W       = POS_W + 2;
	localparam int LIN_W      = 2 * SIDE_W + 1;

	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0]  a_left;
		logic [POS_W-1:0]  a_top;
		logic [SIDE_W-1:0] a_width;
		logic [SIDE_W-1:0] a_height;
		logic [POS_W-1:0]  b_left;
		logic [POS_W-1:0]  b_top;
		logic [SIDE_W-1:0] b_width;
		logic [SIDE_W-1:0] b_height;
	} geom_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} scan_sts_t;

	function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = (32'(v) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : v;
		return r;
	endfunction

endpackage

>>> rtl/core/spc_ram.sv
module spc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/spc_scan.sv
module spc_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  spc_pkg::geom_t             geom,
	input  logic                       out_free,
	output logic                       a_rd_en,
	output logic [spc_pkg::ADDR_W-1:0] a_rd_addr,
	input  logic                       a_rd_data,
	output logic                       b_rd_en,
	output logic [spc_pkg::ADDR_W-1:0] b_rd_addr,
	input  logic                       b_rd_data,
	output spc_pkg::scan_sts_t         sts
);

	spc_pkg::state_t state_q, state_d;

	logic signed [spc_pkg::OFF_W-1:0] off_x_q, off_y_q;
	logic [spc_pkg::SIDE_W-1:0] aw_q, ah_q, bw_q, bh_q;
	logic [spc_pkg::SIDE_W-1:0] col_q, row_q;
	logic [spc_pkg::ADDR_W-1:0] a_idx_q;
	logic                       v_s1, v_s2;
	logic [spc_pkg::SIDE_W-1:0] col_s1, row_s1;
	logic                       hit_q;

	logic                             issue;
	logic                             finished;
	logic signed [spc_pkg::DX_W-1:0]  dx, dy;
	logic                             in_x, in_y;
	logic [spc_pkg::LIN_W-1:0]        b_lin;

	always_comb begin
		dx = spc_pkg::DX_W'(off_x_q) + spc_pkg::DX_W'(signed'({1'b0, col_s1}));
		dy = spc_pkg::DX_W'(off_y_q) + spc_pkg::DX_W'(signed'({1'b0, row_s1}));
		in_x = (dx >= 0) && (dx < spc_pkg::DX_W'(signed'({1'b0, bw_q})));
		in_y = (dy >= 0) && (dy < spc_pkg::DX_W'(signed'({1'b0, bh_q})));
		b_lin = spc_pkg::LIN_W'(dy[spc_pkg::SIDE_W-1:0] * bw_q)
			+ spc_pkg::LIN_W'(dx[spc_pkg::SIDE_W-1:0]);
	end

	always_comb begin
		issue     = (state_q == spc_pkg::ST_SCAN) && !hit_q && (row_q < ah_q) && (aw_q != '0);
		a_rd_en   = issue;
		a_rd_addr = a_idx_q;
		b_rd_en   = (state_q == spc_pkg::ST_SCAN) && v_s1 && a_rd_data && in_x && in_y && !hit_q;
		b_rd_addr = spc_pkg::ADDR_W'(b_lin);
		finished  = hit_q || (!issue && !v_s1 && !v_s2);
		sts.busy  = (state_q != spc_pkg::ST_IDLE);
		sts.done  = (state_q == spc_pkg::ST_DONE) && out_free;
		sts.hit   = hit_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = spc_pkg::ST_SCAN;
				end
			end
			spc_pkg::ST_SCAN: begin
				if (finished) begin
					state_d = spc_pkg::ST_DONE;
				end
			end
			spc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = spc_pkg::ST_IDLE;
				end
			end
			default: state_d = spc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spc_pkg::ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spc_pkg::ST_IDLE) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				if (start) begin
					hit_q <= 1'b0;
				end
			end else begin
				v_s1 <= issue;
				v_s2 <= b_rd_en;
				if (v_s2 && b_rd_data && (state_q == spc_pkg::ST_SCAN)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == spc_pkg::ST_IDLE) && start) begin
			off_x_q <= {geom.a_left[spc_pkg::POS_W-1], geom.a_left}
				- {geom.b_left[spc_pkg::POS_W-1], geom.b_left};
			off_y_q <= {geom.a_top[spc_pkg::POS_W-1], geom.a_top}
				- {geom.b_top[spc_pkg::POS_W-1], geom.b_top};
			aw_q    <= spc_pkg::sat_side(geom.a_width);
			ah_q    <= spc_pkg::sat_side(geom.a_height);
			bw_q    <= spc_pkg::sat_side(geom.b_width);
			bh_q    <= spc_pkg::sat_side(geom.b_height);
			col_q   <= '0;
			row_q   <= '0;
			a_idx_q <= '0;
		end else if (issue) begin
			a_idx_q <= a_idx_q + 1'b1;
			if (col_q == aw_q - 1'b1) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
		col_s1 <= col_q;
		row_s1 <= row_q;
	end

endmodule

>>> rtl/core/sprite_pixel_collision.sv
// Pixel-exact collision test between two sprites of up to 16 by 16 pixels.
// Input channel (in_valid / in_stall) carries one transaction per item:
//   kind load A or load B writes pixel_opaque into that mask at pixel_index
//   (row-major, column plus row times width); indexes past the mask are dropped.
//   kind test scans sprite A against sprite B using the position and size fields.
// Output channel (out_valid / out_stall) carries one hit transaction per test;
// loads and the unused kind give none.
// A load is never stalled while the block is idle.
// A test keeps in_stall high while it runs; a hit ends the scan early. The
// scan reads mask A one pixel per cycle and, once each A bit is read out,
// mask B; the single read port of each mask sets the rate. A zero width or
// height of sprite A gives no hit.
// The result sits in an output register, so a new transaction is taken while it
// waits; a finished test holds in the sequencer while the receiver stalls.
// Reset clears control state only; mask contents are undefined until loaded.
module sprite_pixel_collision (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 kind,
	input  logic [spc_pkg::IDX_IN_W-1:0] pixel_index,
	input  logic                       pixel_opaque,
	input  logic [spc_pkg::POS_W-1:0]  a_left,
	input  logic [spc_pkg::POS_W-1:0]  a_top,
	input  logic [spc_pkg::SIDE_W-1:0] a_width,
	input  logic [spc_pkg::SIDE_W-1:0] a_height,
	input  logic [spc_pkg::POS_W-1:0]  b_left,
	input  logic [spc_pkg::POS_W-1:0]  b_top,
	input  logic [spc_pkg::SIDE_W-1:0] b_width,
	input  logic [spc_pkg::SIDE_W-1:0] b_height,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit
);

	spc_pkg::scan_sts_t         sts;
	spc_pkg::geom_t             geom;
	logic                       accept, start, idx_ok, out_free;
	logic                       wr_a, wr_b;
	logic [spc_pkg::ADDR_W-1:0] wr_addr;
	logic                       a_rd_en, b_rd_en, a_rd_data, b_rd_data;
	logic [spc_pkg::ADDR_W-1:0] a_rd_addr, b_rd_addr;
	logic                       out_valid_q, hit_q;

	always_comb begin
		in_stall = sts.busy;
		accept   = in_valid && !in_stall;
		idx_ok   = 32'(pixel_index) < spc_pkg::MASK_DEPTH;
		wr_addr  = spc_pkg::ADDR_W'(pixel_index);
		wr_a     = accept && idx_ok && (kind == spc_pkg::KIND_LOAD_A);
		wr_b     = accept && idx_ok && (kind == spc_pkg::KIND_LOAD_B);
		start    = accept && (kind == spc_pkg::KIND_TEST);
		out_free = !out_valid_q || !out_stall;
		geom.a_left   = a_left;
		geom.a_top    = a_top;
		geom.a_width  = a_width;
		geom.a_height = a_height;
		geom.b_left   = b_left;
		geom.b_top    = b_top;
		geom.b_width  = b_width;
		geom.b_height = b_height;
	end

	spc_ram #(
		.WIDTH(1),
		.DEPTH(spc_pkg::MASK_DEPTH)
	) u_mask_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (wr_addr),
		.wr_data (pixel_opaque),
		.rd_en   (a_rd_en),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	spc_ram #(
		.WIDTH(1),
		.DEPTH(spc_pkg::MASK_DEPTH)
	) u_mask_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (wr_addr),
		.wr_data (pixel_opaque),
		.rd_en   (b_rd_en),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data)
	);

	spc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.geom      (geom),
		.out_free  (out_free),
		.a_rd_en   (a_rd_en),
		.a_rd_addr (a_rd_addr),
		.a_rd_data (a_rd_data),
		.b_rd_en   (b_rd_en),
		.b_rd_addr (b_rd_addr),
		.b_rd_data (b_rd_data),
		.sts       (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			hit_q <= sts.hit;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

endmodule

>>> rtl/core/spc_checker.sv
`include "sprite_pixel_collision_macros.svh"

module spc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic       hit
);

	`SPC_ASSERT_NEXT(a_test_busy, in_valid && !in_stall && kind == spc_pkg::KIND_TEST, in_stall)
	`SPC_ASSERT_NEXT(a_load_free, in_valid && !in_stall && kind != spc_pkg::KIND_TEST, !in_stall)
	`SPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`SPC_ASSERT_NEXT(a_hit_hold, out_valid && out_stall, $stable(hit))

endmodule

bind sprite_pixel_collision spc_checker u_chk (.*);
